// ----- rtl/segmented_sieve_prime_count_macros.svh -----
// Assertion helpers for the sieve RTL.
`ifndef SEGMENTED_SIEVE_PRIME_COUNT_MACROS_SVH
`define SEGMENTED_SIEVE_PRIME_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ssp_pkg.sv -----
package ssp_pkg;

	// Default sizing
	localparam int MAX_LIMIT_DEF   = 65535;
	localparam int PRIME_SLOTS_DEF = 64;

	// Stream payload widths
	localparam int LIMIT_W = 16;
	localparam int COUNT_W = 13;
	localparam int TDATA_W = 16;

	// Count saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1FFF;

	// Smallest prime
	localparam int MIN_PRIME = 2;

endpackage

// ----- rtl/ssp_ram.sv -----
module ssp_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/ssp_sqrt.sv -----
module ssp_sqrt #(
	parameter int IN_W   = 16,
	parameter int ROOT_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [IN_W-1:0]   operand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	localparam int RAD_W  = 2 * ROOT_W;
	localparam int STEP_W = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [ROOT_W:0]   rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              fits;
	logic [ROOT_W+1:0] rem_sub;

	// Bring down the next two radicand bits and try the next root bit
	assign rem_sh  = {rem_q[ROOT_W-1:0], rad_q[RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign fits    = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	// Control: one root bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == STEP_W'(ROOT_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'(operand);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= rad_q << 2;
			rem_q  <= fits ? rem_sub[ROOT_W:0] : rem_sh[ROOT_W:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

// ----- rtl/segmented_sieve_prime_count.sv -----
// Channel   Dir  Fields (tdata, low bit up)             Beat
// s_axis    in   limit_n[15:0]                          one limit per request
// m_axis    out  prime_count[12:0], zero pad [15:13]    one count per request
//
// The composite map RAM, with one write port and one registered read port, takes one
// clear, strike or scan read per cycle. The map is cleared over 0..n at the start of
// every request with a limit of 2 or more, so no clearing pass follows reset. A new
// limit is taken only when idle; a finished count holds the input until it moves into
// the output register, where it waits without holding the input.
`include "segmented_sieve_prime_count_macros.svh"

module segmented_sieve_prime_count #(
	parameter int MAX_LIMIT   = ssp_pkg::MAX_LIMIT_DEF,
	parameter int PRIME_SLOTS = ssp_pkg::PRIME_SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [ssp_pkg::TDATA_W-1:0] s_axis_tdata,  // [15:0] limit_n
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [ssp_pkg::TDATA_W-1:0] m_axis_tdata   // [12:0] prime_count, [15:13] zero
);

	localparam int LW     = $clog2(MAX_LIMIT + 1);
	localparam int SW     = LW + 1;
	localparam int RW     = (LW + 1) / 2;
	localparam int SAW    = $clog2(PRIME_SLOTS);
	localparam int TW     = $clog2(PRIME_SLOTS + 1);
	localparam int SLOT_W = RW + SW;
	localparam int CW     = ssp_pkg::COUNT_W;

	typedef enum logic [12:0] {
		ST_IDLE    = 13'b0000000000001,
		ST_CLEAR   = 13'b0000000000010,
		ST_ROOT    = 13'b0000000000100,
		ST_BREAD   = 13'b0000000001000,
		ST_BCHK    = 13'b0000000010000,
		ST_BSTRIKE = 13'b0000000100000,
		ST_BSAVE   = 13'b0000001000000,
		ST_WSTART  = 13'b0000010000000,
		ST_SLOAD   = 13'b0000100000000,
		ST_SGET    = 13'b0001000000000,
		ST_SSTRIKE = 13'b0010000000000,
		ST_SSTORE  = 13'b0100000000000,
		ST_SCAN    = 13'b1000000000000
	} state_t;

	// Finish is folded into the idle-bound path through a flag
	state_t          state_q;
	logic            finish_q;

	logic [LW-1:0]   n_q;
	logic [RW-1:0]   m_q;
	logic [RW-1:0]   i_q;
	logic [RW-1:0]   p_q;
	logic [SW-1:0]   pos_q;
	logic [SW-1:0]   win_q;
	logic [SW-1:0]   end_q;
	logic [SW-1:0]   ptr_q;
	logic [SAW-1:0]  k_q;
	logic [TW-1:0]   total_q;
	logic [CW-1:0]   cnt_q;
	logic            scan_vld_s1;
	logic            out_valid_q;
	logic [CW-1:0]   out_data_q;

	logic            in_fire;
	logic [31:0]     lim_ext;
	logic [LW-1:0]   lim_sat;
	logic            sqrt_busy;
	logic [RW-1:0]   sqrt_root;

	logic            map_we;
	logic [LW-1:0]   map_waddr;
	logic            map_wdata;
	logic [LW-1:0]   map_raddr;
	logic            map_rdata;

	logic            slot_we;
	logic [SAW-1:0]  slot_waddr;
	logic [SLOT_W-1:0] slot_wdata;
	logic [SLOT_W-1:0] slot_rdata;

	logic            i_last;
	logic            slot_free;
	logic            k_last;
	logic [SW-1:0]   end_sum;
	logic            scan_issue;
	logic            scan_bump;
	logic            base_bump;
	logic            out_load;

	// Input beat and limit saturation
	assign s_axis_tready = (state_q == ST_IDLE) && !finish_q;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign lim_ext       = 32'(s_axis_tdata);
	assign lim_sat       = (lim_ext > 32'(MAX_LIMIT)) ? LW'(MAX_LIMIT) : LW'(lim_ext);

	// Loop conditions
	assign i_last     = (i_q == m_q);
	assign slot_free  = (total_q < TW'(PRIME_SLOTS));
	assign k_last     = ((TW'(k_q) + 1'b1) == total_q);
	assign end_sum    = win_q + SW'(m_q) - 1'b1;
	assign scan_issue = (state_q == ST_SCAN) && (ptr_q <= end_q);
	assign scan_bump  = scan_vld_s1 && !map_rdata;
	assign base_bump  = (state_q == ST_BSAVE);
	assign out_load   = finish_q && (!out_valid_q || m_axis_tready);

	// Integer square root, started with the request
	ssp_sqrt #(
		.IN_W   (LW),
		.ROOT_W (RW)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.operand (lim_sat),
		.busy    (sqrt_busy),
		.root    (sqrt_root)
	);

	// Composite map port steering
	always_comb begin
		map_we    = 1'b0;
		map_waddr = ptr_q[LW-1:0];
		map_wdata = 1'b0;
		map_raddr = ptr_q[LW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
			end
			ST_BSTRIKE: begin
				map_we    = (pos_q <= SW'(m_q));
				map_waddr = pos_q[LW-1:0];
				map_wdata = 1'b1;
			end
			ST_SSTRIKE: begin
				map_we    = (pos_q <= end_q);
				map_waddr = pos_q[LW-1:0];
				map_wdata = 1'b1;
			end
			ST_BREAD: begin
				map_raddr = LW'(i_q);
			end
			default: begin
			end
		endcase
	end

	ssp_ram #(
		.WIDTH (1),
		.DEPTH (MAX_LIMIT + 1)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// Slot table: base prime over next strike position
	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = k_q;
		slot_wdata = {p_q, pos_q};
		if (state_q == ST_BSAVE) begin
			slot_we    = slot_free;
			slot_waddr = total_q[SAW-1:0];
			slot_wdata = {i_q, pos_q};
		end else if (state_q == ST_SSTORE) begin
			slot_we = 1'b1;
		end
	end

	ssp_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (PRIME_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (k_q),
		.rdata (slot_rdata)
	);

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			finish_q    <= 1'b0;
			total_q     <= '0;
			cnt_q       <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_issue;

			// Count one prime, saturating
			if ((base_bump || scan_bump) && (cnt_q != ssp_pkg::COUNT_MAX)) begin
				cnt_q <= cnt_q + 1'b1;
			end

			// Output register
			if (out_load) begin
				out_valid_q <= 1'b1;
				finish_q    <= 1'b0;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q   <= '0;
						total_q <= '0;
						if (lim_sat < LW'(ssp_pkg::MIN_PRIME)) begin
							finish_q <= 1'b1;
						end else begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (ptr_q == SW'(n_q)) begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					if (!sqrt_busy) begin
						state_q <= (sqrt_root < RW'(ssp_pkg::MIN_PRIME)) ? ST_WSTART : ST_BREAD;
					end
				end
				ST_BREAD: begin
					state_q <= ST_BCHK;
				end
				ST_BCHK: begin
					if (!map_rdata) begin
						state_q <= ST_BSTRIKE;
					end else if (i_last) begin
						state_q <= ST_WSTART;
					end else begin
						state_q <= ST_BREAD;
					end
				end
				ST_BSTRIKE: begin
					if (pos_q > SW'(m_q)) begin
						state_q <= ST_BSAVE;
					end
				end
				ST_BSAVE: begin
					if (slot_free) begin
						total_q <= total_q + 1'b1;
					end
					state_q <= i_last ? ST_WSTART : ST_BREAD;
				end
				ST_WSTART: begin
					if (win_q > SW'(n_q)) begin
						state_q  <= ST_IDLE;
						finish_q <= 1'b1;
					end else if (total_q == '0) begin
						state_q <= ST_SCAN;
					end else begin
						state_q <= ST_SLOAD;
					end
				end
				ST_SLOAD: begin
					state_q <= ST_SGET;
				end
				ST_SGET: begin
					state_q <= ST_SSTRIKE;
				end
				ST_SSTRIKE: begin
					if (pos_q > end_q) begin
						state_q <= ST_SSTORE;
					end
				end
				ST_SSTORE: begin
					state_q <= k_last ? ST_SCAN : ST_SLOAD;
				end
				ST_SCAN: begin
					if (!scan_issue && !scan_vld_s1) begin
						state_q <= ST_WSTART;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= cnt_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				n_q   <= lim_sat;
				ptr_q <= '0;
			end
			ST_CLEAR: begin
				ptr_q <= ptr_q + 1'b1;
			end
			ST_ROOT: begin
				m_q   <= sqrt_root;
				i_q   <= RW'(ssp_pkg::MIN_PRIME);
				win_q <= SW'(sqrt_root) + 1'b1;
			end
			ST_BCHK: begin
				pos_q <= SW'({i_q, 1'b0});
				if (map_rdata && !i_last) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_BSTRIKE: begin
				if (pos_q <= SW'(m_q)) begin
					pos_q <= pos_q + SW'(i_q);
				end
			end
			ST_BSAVE: begin
				if (!i_last) begin
					i_q <= i_q + 1'b1;
				end
			end
			ST_WSTART: begin
				end_q <= (end_sum > SW'(n_q)) ? SW'(n_q) : end_sum;
				ptr_q <= win_q;
				k_q   <= '0;
			end
			ST_SGET: begin
				p_q   <= slot_rdata[SLOT_W-1:SW];
				pos_q <= slot_rdata[SW-1:0];
			end
			ST_SSTRIKE: begin
				if (pos_q <= end_q) begin
					pos_q <= pos_q + SW'(p_q);
				end
			end
			ST_SSTORE: begin
				if (!k_last) begin
					k_q <= k_q + 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_issue) begin
					ptr_q <= ptr_q + 1'b1;
				end else if (!scan_vld_s1) begin
					win_q <= win_q + SW'(m_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ssp_pkg::TDATA_W'(out_data_q);

	// Strikes and clears stay inside the requested range
	`SSP_ASSERT_NOW(a_map_write_range, clk, arst_n, map_we, map_waddr <= n_q, "map write beyond limit")
	// Kept base primes never exceed the slot table
	`SSP_ASSERT_NOW(a_slot_bound, clk, arst_n, 1'b1, total_q <= TW'(PRIME_SLOTS), "slot count overrun")
	// Scan reads stay between the window start and the limit
	`SSP_ASSERT_NOW(a_scan_range, clk, arst_n, scan_issue, (ptr_q >= win_q) && (ptr_q <= SW'(n_q)), "scan outside window")
	// A limit starts a clear or finishes at once
	`SSP_ASSERT_NEXT(a_accept_next, clk, arst_n, in_fire, (state_q == ST_CLEAR) || finish_q, "bad state after accept")

endmodule

// ----- tb/segmented_sieve_prime_count_tb.sv -----
module segmented_sieve_prime_count_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ssp_pkg::*;

	localparam int MAP_TOP      = MAX_LIMIT_DEF;
	localparam int SLOTS        = PRIME_SLOTS_DEF;
	localparam int N_DIRECTED   = 20;
	localparam int N_RANDOM     = 100;
	localparam int HOLD_CYCLES  = 20000;
	localparam int HOLD_AT      = 30;
	localparam int CALM_FIRST   = 40;
	localparam int CALM_LAST    = 69;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [LIMIT_W-1:0] limit;
		logic               known;
		logic [COUNT_W-1:0] count;
	} limit_case_t;

	// Rows with known set carry a count read straight off the definition
	limit_case_t directed_cases [N_DIRECTED] = '{
		'{16'd0,     1'b1, 13'd0},
		'{16'd65535, 1'b1, 13'd6542},
		'{16'd1,     1'b1, 13'd0},
		'{16'd2,     1'b1, 13'd1},
		'{16'd3,     1'b1, 13'd2},
		'{16'd4,     1'b0, 13'd0},
		'{16'd5,     1'b0, 13'd0},
		'{16'd8,     1'b0, 13'd0},
		'{16'd9,     1'b0, 13'd0},
		'{16'd24,    1'b0, 13'd0},
		'{16'd25,    1'b0, 13'd0},
		'{16'd26,    1'b0, 13'd0},
		'{16'd48,    1'b0, 13'd0},
		'{16'd49,    1'b0, 13'd0},
		'{16'd120,   1'b0, 13'd0},
		'{16'd121,   1'b0, 13'd0},
		'{16'd255,   1'b0, 13'd0},
		'{16'd256,   1'b0, 13'd0},
		'{16'd1000,  1'b0, 13'd0},
		'{16'd4096,  1'b0, 13'd0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic [TDATA_W-1:0] s_tdata = '0;
	logic               s_tready;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;

	logic [COUNT_W-1:0] pending_counts [$];
	int                 fails = 0;
	int                 counts_seen = 0;
	bit                 calm = 1'b0;
	bit                 hold_done = 1'b0;

	// Predictor state
	bit          sieve_map [0:MAP_TOP];
	int unsigned kept_prime [SLOTS];
	int unsigned kept_next [SLOTS];

	segmented_sieve_prime_count i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Integer floor square root, digit by digit
	function automatic int unsigned floor_root(int unsigned v);
		int unsigned root;
		int unsigned probe;
		root = 0;
		probe = 32'h4000_0000;
		while (probe > v) probe >>= 2;
		while (probe != 0) begin
			if (v >= root + probe) begin
				v -= root + probe;
				root = (root >> 1) + probe;
			end else begin
				root >>= 1;
			end
			probe >>= 2;
		end
		return root;
	endfunction

	// Mark multiples up to stop; hand back the first one left unmarked
	function automatic int unsigned strike_through(int unsigned pos, int unsigned step,
			int unsigned stop);
		while (pos <= stop) begin
			sieve_map[pos] = 1'b1;
			pos += step;
		end
		return pos;
	endfunction

	// Blocked sieve: base primes up to the root, then windows of root width
	function automatic logic [COUNT_W-1:0] count_primes(logic [LIMIT_W-1:0] limit_n);
		int unsigned n, m, i, k, nxt, span_lo, span_hi, kept, total;
		n = limit_n;
		if (n > MAP_TOP) n = MAP_TOP;
		total = 0;
		kept = 0;
		if (n >= MIN_PRIME) begin
			for (i = 0; i <= n; i++) sieve_map[i] = 1'b0;
			m = floor_root(n);
			for (i = MIN_PRIME; i <= m; i++) begin
				if (!sieve_map[i]) begin
					nxt = strike_through(2 * i, i, m);
					if (total < COUNT_MAX) total++;
					// a prime past the last slot is counted but not kept
					if (kept < SLOTS) begin
						kept_next[kept] = nxt;
						kept_prime[kept] = i;
						kept++;
					end
				end
			end
			for (span_lo = m + 1; span_lo <= n; span_lo += m) begin
				span_hi = span_lo + m - 1;
				if (span_hi > n) span_hi = n;
				for (k = 0; k < kept; k++)
					kept_next[k] = strike_through(kept_next[k], kept_prime[k], span_hi);
				for (i = span_lo; i <= span_hi; i++)
					if (!sieve_map[i] && total < COUNT_MAX) total++;
			end
		end
		return total[COUNT_W-1:0];
	endfunction

	// Mostly small limits, some near perfect squares, a few larger ones
	function automatic logic [LIMIT_W-1:0] pick_limit();
		int unsigned r;
		int unsigned root;
		r = $urandom_range(99);
		if (r < 15) begin
			root = $urandom_range(24, 2);
			return LIMIT_W'(root * root + $urandom_range(2) - 1);
		end
		if (r < 85) return LIMIT_W'($urandom_range(600));
		if (r < 97) return LIMIT_W'($urandom_range(4095));
		return LIMIT_W'($urandom_range(16383));
	endfunction

	// Offer one limit, hold it until taken, then queue its count
	task automatic send_limit(input logic [LIMIT_W-1:0] lim, input logic [COUNT_W-1:0] want);
		if (!calm && $urandom_range(99) < 23) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < 23) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= lim;
		do @(posedge clk); while (!s_tready);
		pending_counts.push_back(want);
	endtask

	// Compare one count beat with the oldest expectation
	task automatic check_count(input logic [TDATA_W-1:0] beat);
		logic [COUNT_W-1:0] want;
		counts_seen++;
		if (pending_counts.size() == 0) begin
			$display("%0t: count beat %0d with none expected", $time, beat[COUNT_W-1:0]);
			fails++;
		end else begin
			want = pending_counts.pop_front();
			if (beat[COUNT_W-1:0] !== want) begin
				$display("%0t: prime_count expected %0d actual %0d", $time, want,
					beat[COUNT_W-1:0]);
				fails++;
			end
			if (beat[TDATA_W-1:COUNT_W] !== '0) begin
				$display("%0t: pad bits expected 0 actual %0h", $time,
					beat[TDATA_W-1:COUNT_W]);
				fails++;
			end
		end
	endtask

	// Result side: random stalls, one long hold-off, a calm stretch
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) check_count(m_tdata);
			if (!hold_done && counts_seen == HOLD_AT) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= calm || $urandom_range(99) >= 23;
			end
		end
	end

	// Reset, directed table, random limits, drain
	initial begin
		logic [LIMIT_W-1:0] lim;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < N_DIRECTED; row++) begin
			lim = directed_cases[row].limit;
			send_limit(lim, directed_cases[row].known ? directed_cases[row].count
				: count_primes(lim));
		end

		for (int idx = 0; idx < N_RANDOM; idx++) begin
			calm = idx >= CALM_FIRST && idx <= CALM_LAST;
			lim = pick_limit();
			send_limit(lim, count_primes(lim));
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending_counts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0) begin
			$display("[segmented_sieve_prime_count] OK");
		end else begin
			$display("[segmented_sieve_prime_count] ERROR");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#60ms;
		$display("[segmented_sieve_prime_count] ERROR");
		$finish;
	end

endmodule
